// ===== src/ddp_rx_pkg.sv =====
// Shared types, constants and register codes for the DDP pixel frame receiver.
package ddp_rx_pkg;

  // Default sizes
  localparam int FRAME_BYTES_DEF  = 16384;
  localparam int HEADER_BYTES_DEF = 10;
  localparam int MAX_DATAGRAM_DEF = 2048;

  // Fixed field widths of the ports
  localparam int DLEN_W       = 12;
  localparam int RADDR_W      = 14;
  localparam int PACKET_W     = 32;
  localparam int BYTES_W      = 40;
  localparam int PIXEL_W      = 13;
  localparam int FRAME_SIZE_W = 15;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATS_ENABLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION_VALUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_DEST_ID = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RGB_TYPE_CODE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD_LEN = 3'd6;

  // Register reset values
  localparam logic [7:0]  VERSION_MASK_RST    = 8'd192;
  localparam logic [7:0]  VERSION_VALUE_RST   = 8'd64;
  localparam logic [7:0]  DISPLAY_DEST_ID_RST = 8'd1;
  localparam logic [7:0]  RGB_TYPE_CODE_RST   = 8'd11;
  localparam logic [10:0] MAX_PAYLOAD_LEN_RST = 11'd1440;

  // Header byte positions
  localparam int POS_FLAGS   = 0;
  localparam int POS_TYPE    = 2;
  localparam int POS_DEST    = 3;
  localparam int POS_OFFSET3 = 4;
  localparam int POS_OFFSET2 = 5;
  localparam int POS_OFFSET1 = 6;
  localparam int POS_OFFSET0 = 7;
  localparam int POS_LENGTH1 = 8;
  localparam int POS_LENGTH0 = 9;

  // Header check settings
  typedef struct packed {
    logic        receive_enable;
    logic [7:0]  version_mask;
    logic [7:0]  version_value;
    logic [7:0]  dest_id;
    logic [7:0]  type_code;
    logic [10:0] max_len;
  } rx_cfg_t;

  // Per-transaction event from the parser to the statistics
  typedef struct packed {
    logic              fin;      // end marker seen with receive enabled
    logic              acc;      // datagram accepted
    logic [32:0]       extent;   // offset + length
    logic [DLEN_W-1:0] dlen;     // clamped datagram length
    logic              wr_over;  // payload byte fell beyond the frame
  } rx_evt_t;

endpackage

// ===== src/ddp_rx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ddp_rx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ddp_rx_parser.sv =====
// Header capture, header checks and payload write generation.
module ddp_rx_parser
  import ddp_rx_pkg::*;
#(
  parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_DATAGRAM = MAX_DATAGRAM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic [7:0]                     data_byte,
  input  logic                           last,
  input  logic [DLEN_W-1:0]              dlen_raw,
  input  rx_cfg_t                        cfg,
  output rx_evt_t                        evt,
  output logic                           wr_en,
  output logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
  output logic [7:0]                     wr_data
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int PW = $clog2(MAX_DATAGRAM + 1);
  localparam int CW = (PW > DLEN_W) ? PW : DLEN_W;

  logic [PW-1:0] byte_position, byte_position_next;
  logic [7:0]    hdr_flags, hdr_type, hdr_dest;
  logic [31:0]   hdr_offset;
  logic [15:0]   hdr_length;
  logic          packet_ok, packet_ok_next;

  logic [7:0]        flags_m, type_m, dest_m;
  logic [31:0]       offset_m;
  logic [15:0]       length_m;
  logic [DLEN_W-1:0] dlen_c;
  logic [PW-1:0]     idx;
  logic [32:0]       wa;
  logic              in_header, check_pos, hdr_pass, ok_new;
  logic              payload, in_frame;

  // Clamp the datagram length
  assign dlen_c = (CW'(dlen_raw) > CW'(MAX_DATAGRAM)) ? DLEN_W'(MAX_DATAGRAM) : dlen_raw;

  // Header fields with the current byte merged in
  always_comb begin
    flags_m  = hdr_flags;
    type_m   = hdr_type;
    dest_m   = hdr_dest;
    offset_m = hdr_offset;
    length_m = hdr_length;
    if (byte_position == PW'(POS_FLAGS))   flags_m         = data_byte;
    if (byte_position == PW'(POS_TYPE))    type_m          = data_byte;
    if (byte_position == PW'(POS_DEST))    dest_m          = data_byte;
    if (byte_position == PW'(POS_OFFSET3)) offset_m[31:24] = data_byte;
    if (byte_position == PW'(POS_OFFSET2)) offset_m[23:16] = data_byte;
    if (byte_position == PW'(POS_OFFSET1)) offset_m[15:8]  = data_byte;
    if (byte_position == PW'(POS_OFFSET0)) offset_m[7:0]   = data_byte;
    if (byte_position == PW'(POS_LENGTH1)) length_m[15:8]  = data_byte;
    if (byte_position == PW'(POS_LENGTH0)) length_m[7:0]   = data_byte;
  end

  // Header checks on the last header byte
  assign in_header = byte_position < PW'(HEADER_BYTES);
  assign check_pos = byte_position == PW'(HEADER_BYTES - 1);
  assign hdr_pass  = (dlen_c >= DLEN_W'(HEADER_BYTES))
                  && ((flags_m & cfg.version_mask) == cfg.version_value)
                  && (dest_m == cfg.dest_id)
                  && (type_m == cfg.type_code)
                  && (length_m <= 16'(dlen_c - DLEN_W'(HEADER_BYTES)))
                  && (length_m <= 16'(cfg.max_len));
  assign ok_new    = check_pos ? hdr_pass : packet_ok;

  // Payload write address
  assign idx      = byte_position - PW'(HEADER_BYTES);
  assign wa       = 33'(hdr_offset) + 33'(idx);
  assign payload  = !in_header && packet_ok && (CW'(byte_position) < CW'(dlen_c))
                 && (16'(idx) < hdr_length);
  assign in_frame = wa < 33'(FRAME_BYTES);

  assign wr_en   = fire && cfg.receive_enable && payload && in_frame;
  assign wr_addr = AW'(wa);
  assign wr_data = data_byte;

  // Event toward the statistics
  always_comb begin
    evt.fin     = fire && cfg.receive_enable && last;
    evt.acc     = ok_new && (byte_position >= PW'(HEADER_BYTES - 1));
    evt.extent  = 33'(offset_m) + 33'(length_m);
    evt.dlen    = dlen_c;
    evt.wr_over = fire && cfg.receive_enable && payload && !in_frame;
  end

  // Position and packet state
  always_comb begin
    byte_position_next = byte_position;
    packet_ok_next     = packet_ok;
    if (fire) begin
      if (!cfg.receive_enable || last) begin
        byte_position_next = '0;
        packet_ok_next     = 1'b0;
      end else begin
        packet_ok_next = ok_new;
        if (byte_position < PW'(MAX_DATAGRAM)) begin
          byte_position_next = byte_position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      packet_ok     <= 1'b0;
      hdr_flags     <= '0;
      hdr_type      <= '0;
      hdr_dest      <= '0;
      hdr_offset    <= '0;
      hdr_length    <= '0;
    end else begin
      byte_position <= byte_position_next;
      packet_ok     <= packet_ok_next;
      if (fire && cfg.receive_enable) begin
        hdr_flags  <= flags_m;
        hdr_type   <= type_m;
        hdr_dest   <= dest_m;
        hdr_offset <= offset_m;
        hdr_length <= length_m;
      end
    end
  end

`ifndef SYNTH
  // Position never runs past the datagram limit
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    byte_position <= PW'(MAX_DATAGRAM))
    else $error("byte position beyond datagram limit");

  // An end marker always rewinds the position
  a_end_rewind: assert property (@(posedge clk) disable iff (rst)
    fire && last |=> byte_position == '0 && !packet_ok)
    else $error("position not rewound after end marker");
`endif

endmodule

// ===== src/ddp_rx_stats.sv =====
// High-water frame size, overflow flag and packet and byte counters.
module ddp_rx_stats
  import ddp_rx_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rx_evt_t                          evt,
  input  logic                             stats_enable,
  input  logic                             stats_clear,
  output logic [PACKET_W-1:0]              packets_next,
  output logic [BYTES_W-1:0]               bytes_next,
  output logic [$clog2(FRAME_BYTES+1)-1:0] hw_next,
  output logic                             overflow_next
);

  localparam int HWW = $clog2(FRAME_BYTES + 1);

  logic [PACKET_W-1:0] packets_seen;
  logic [BYTES_W-1:0]  bytes_seen;
  logic [HWW-1:0]      high_water;
  logic                overflow_flag;

  logic           end_acc, ext_over;
  logic [HWW-1:0] ext_sat;

  assign end_acc  = evt.fin && evt.acc;
  assign ext_over = evt.extent > 33'(FRAME_BYTES);
  assign ext_sat  = ext_over ? HWW'(FRAME_BYTES) : HWW'(evt.extent);

  // Next values, also handed out as the status snapshot
  always_comb begin
    hw_next       = high_water;
    overflow_next = overflow_flag || evt.wr_over || (end_acc && ext_over);
    packets_next  = packets_seen;
    bytes_next    = bytes_seen;
    if (end_acc && (ext_sat > high_water)) begin
      hw_next = ext_sat;
    end
    if (stats_clear) begin
      packets_next = '0;
      bytes_next   = '0;
    end else if (end_acc && stats_enable) begin
      packets_next = packets_seen + 1'b1;
      bytes_next   = bytes_seen + BYTES_W'(evt.dlen);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packets_seen  <= '0;
      bytes_seen    <= '0;
      high_water    <= '0;
      overflow_flag <= 1'b0;
    end else begin
      packets_seen  <= packets_next;
      bytes_seen    <= bytes_next;
      high_water    <= hw_next;
      overflow_flag <= overflow_next;
    end
  end

`ifndef SYNTH
  // Frame size is saturated at capacity
  a_hw_cap: assert property (@(posedge clk) disable iff (rst)
    high_water <= HWW'(FRAME_BYTES))
    else $error("high-water size beyond frame capacity");

  // Overflow is sticky
  a_over_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |=> overflow_flag)
    else $error("overflow flag dropped");
`endif

endmodule

// ===== src/ddp_pixel_frame_receiver_top.sv =====
// Top level of the DDP pixel frame receiver: channels, config and frame store.
//
// Input channel (in_valid/in_ready): one transaction per datagram byte (func 0)
// or per frame store read (func 1). Output channel (out_valid/out_ready): one
// status transaction on each datagram end marker, one read-data transaction
// per read. Other datagram bytes give no output.
// A transaction is held in the input register, runs through the header
// logic and a frame-store port, and lands in the result register, which
// offers it on out_valid until out_ready takes it.
// Throughput is one transaction per cycle when nothing stalls, as each uses
// one payload write or one read of the frame store and combinational header logic.
// When the receiver holds out_ready low, the result register holds and the
// input register may still take one transaction; bytes that give no output
// keep flowing until a result-bearing one must wait.
// After reset the frame store is cleared by a sweep of all FRAME_BYTES addresses,
// one byte per cycle; in_ready stays low during it, config writes are taken.
// Config writes (cfg_write, cfg_index, cfg_data) land at the clock edge and
// are expected only while the block is idle.
module ddp_pixel_frame_receiver_top
  import ddp_rx_pkg::*;
#(
  parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_DATAGRAM = MAX_DATAGRAM_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    func,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_datagram,
  input  logic [DLEN_W-1:0]       datagram_length,
  input  logic [RADDR_W-1:0]      read_address,
  // output channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    result_kind,
  output logic                    accepted,
  output logic [7:0]              read_byte,
  output logic [PACKET_W-1:0]     packet_count,
  output logic [BYTES_W-1:0]      byte_count,
  output logic [PIXEL_W-1:0]      pixel_total,
  output logic [FRAME_SIZE_W-1:0] frame_size,
  output logic                    overflow
);

  localparam int AW       = $clog2(FRAME_BYTES);
  localparam int HWW      = $clog2(FRAME_BYTES + 1);
  localparam int RDW      = (AW + 1 > RADDR_W) ? AW + 1 : RADDR_W;
  localparam int DIVK     = HWW + 1;
  localparam int DIV3_MUL = ((1 << DIVK) + 2) / 3;
  localparam int PRODW    = HWW + DIVK;

  // Config registers
  rx_cfg_t cfg;
  logic    stats_enable;
  logic    stats_clear;

  // Input register
  logic                s1_valid, s1_func, s1_last, s1_has_result, s1_fire;
  logic [7:0]          s1_byte;
  logic [DLEN_W-1:0]   s1_dlen;
  logic [RADDR_W-1:0]  s1_addr;

  // Result register
  logic                s2_valid, s2_kind, s2_acc, s2_rd_ok, s2_over;
  logic [PACKET_W-1:0] s2_packets;
  logic [BYTES_W-1:0]  s2_bytes;
  logic [HWW-1:0]      s2_hw;

  // Frame store clearing sweep
  logic          clearing;
  logic [AW-1:0] clr_addr;

  rx_evt_t             evt;
  logic                item_we;
  logic [AW-1:0]       item_waddr;
  logic [7:0]          item_wdata;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata, ram_rdata;
  logic [PACKET_W-1:0] packets_next;
  logic [BYTES_W-1:0]  bytes_next;
  logic [HWW-1:0]      hw_next;
  logic                overflow_next;
  logic [PRODW-1:0]    div_prod;
  logic [HWW-1:0]      div_quo;

  // Configuration writes
  assign stats_clear = cfg_write && (cfg_index == REG_STATS_ENABLE)
                    && (cfg_data[0] != stats_enable);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.receive_enable <= 1'b1;
      cfg.version_mask   <= VERSION_MASK_RST;
      cfg.version_value  <= VERSION_VALUE_RST;
      cfg.dest_id        <= DISPLAY_DEST_ID_RST;
      cfg.type_code      <= RGB_TYPE_CODE_RST;
      cfg.max_len        <= MAX_PAYLOAD_LEN_RST;
      stats_enable       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RECEIVE_ENABLE:  cfg.receive_enable <= cfg_data[0];
        REG_STATS_ENABLE:    stats_enable       <= cfg_data[0];
        REG_VERSION_MASK:    cfg.version_mask   <= cfg_data[7:0];
        REG_VERSION_VALUE:   cfg.version_value  <= cfg_data[7:0];
        REG_DISPLAY_DEST_ID: cfg.dest_id        <= cfg_data[7:0];
        REG_RGB_TYPE_CODE:   cfg.type_code      <= cfg_data[7:0];
        REG_MAX_PAYLOAD_LEN: cfg.max_len        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control
  assign s1_has_result = s1_func || s1_last;
  assign s1_fire       = s1_valid && (!s1_has_result || !s2_valid || out_ready);
  assign in_ready      = !clearing && (!s1_valid || s1_fire);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func <= func;
      s1_byte <= data_byte;
      s1_last <= end_of_datagram;
      s1_dlen <= datagram_length;
      s1_addr <= read_address;
    end
  end

  ddp_rx_parser #(
    .FRAME_BYTES (FRAME_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .fire     (s1_fire && !s1_func),
    .data_byte(s1_byte),
    .last     (s1_last),
    .dlen_raw (s1_dlen),
    .cfg      (cfg),
    .evt      (evt),
    .wr_en    (item_we),
    .wr_addr  (item_waddr),
    .wr_data  (item_wdata)
  );

  ddp_rx_stats #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_stats (
    .clk          (clk),
    .rst          (rst),
    .evt          (evt),
    .stats_enable (stats_enable),
    .stats_clear  (stats_clear),
    .packets_next (packets_next),
    .bytes_next   (bytes_next),
    .hw_next      (hw_next),
    .overflow_next(overflow_next)
  );

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(FRAME_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Frame store port muxing
  assign ram_we    = clearing || item_we;
  assign ram_waddr = clearing ? clr_addr : item_waddr;
  assign ram_wdata = clearing ? 8'd0 : item_wdata;
  assign ram_re    = s1_fire && s1_func;

  ddp_rx_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_frame_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(AW'(s1_addr)),
    .rdata(ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_fire && s1_has_result) begin
      s2_valid <= 1'b1;
    end else if (out_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_has_result) begin
      s2_kind  <= s1_func;
      s2_rd_ok <= s1_func && (RDW'(s1_addr) < RDW'(FRAME_BYTES));
      if (!s1_func && cfg.receive_enable) begin
        s2_acc     <= evt.fin && evt.acc;
        s2_packets <= packets_next;
        s2_bytes   <= bytes_next;
        s2_hw      <= hw_next;
        s2_over    <= overflow_next;
      end else begin
        s2_acc     <= 1'b0;
        s2_packets <= '0;
        s2_bytes   <= '0;
        s2_hw      <= '0;
        s2_over    <= 1'b0;
      end
    end
  end

  // Pixel count: divide by three through a reciprocal multiply
  assign div_prod = PRODW'(s2_hw) * PRODW'(DIV3_MUL);
  assign div_quo  = HWW'(div_prod >> DIVK);

  assign out_valid    = s2_valid;
  assign result_kind  = s2_kind;
  assign accepted     = s2_acc;
  assign read_byte    = s2_rd_ok ? ram_rdata : 8'd0;
  assign packet_count = s2_packets;
  assign byte_count   = s2_bytes;
  assign pixel_total  = PIXEL_W'(div_quo);
  assign frame_size   = FRAME_SIZE_W'(s2_hw);
  assign overflow     = s2_over;

`ifndef SYNTH
  // No transaction is taken during the clearing sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input accepted while frame store clears");

  // A waiting result is never dropped or replaced
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_ready |=> s2_valid && $stable(s2_kind) && $stable(s2_hw))
    else $error("waiting result changed");

  // Payload writes never collide with the clearing sweep
  a_no_write_clear: assert property (@(posedge clk) disable iff (rst)
    !(clearing && item_we))
    else $error("payload write during clearing sweep");
`endif

endmodule
